FILE: rtl/core/assert_macros.svh
// assertion macros shared by the stack engine rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent that must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/bse_pkg.sv
// shared types and codes of the bytecode stack engine
`default_nettype none

package bse_pkg;

   localparam int DATA_W = 32;

   // operation codes
   localparam logic [2:0] OP_PUSH = 3'd0;
   localparam logic [2:0] OP_LIST = 3'd1;
   localparam logic [2:0] OP_PEEK = 3'd2;
   localparam logic [2:0] OP_POP  = 3'd3;
   localparam logic [2:0] OP_SWAP = 3'd4;

   // status codes
   localparam logic [2:0] STATUS_OK     = 3'd0;
   localparam logic [2:0] STATUS_EMPTY  = 3'd1;
   localparam logic [2:0] STATUS_SHORT  = 3'd2;
   localparam logic [2:0] STATUS_FULL   = 3'd3;
   localparam logic [2:0] STATUS_HALTED = 3'd4;

   // control of one result, handed from the sequencer to the result stage
   typedef struct packed {
      logic       strobe;
      logic       from_ram;
      logic       has_value;
      logic [2:0] status;
      logic       last;
   } rsp_ctl_type;

endpackage

`default_nettype wire

FILE: rtl/core/bse_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none

module bse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/bse_rsp.sv
// result output stage: registers result control, selects ram data
`default_nettype none

module bse_rsp (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire bse_pkg::rsp_ctl_type           ctl_in,
   input  wire logic [bse_pkg::DATA_W-1:0]     ram_data,
   output logic                                rsp_strobe,
   output logic signed [bse_pkg::DATA_W-1:0]   rsp_data_value,
   output logic                                rsp_has_value,
   output logic [2:0]                          rsp_status,
   output logic                                rsp_last
);

   bse_pkg::rsp_ctl_type ctl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   // ram read data is valid from the cycle after the read was issued
   assign rsp_strobe     = ctl_ff.strobe;
   assign rsp_data_value = ctl_ff.from_ram ? signed'(ram_data) : '0;
   assign rsp_has_value  = ctl_ff.has_value;
   assign rsp_status     = ctl_ff.status;
   assign rsp_last       = ctl_ff.last;

endmodule

`default_nettype wire

FILE: rtl/core/bytecode_stack_engine.sv
// top level of the bytecode stack engine: sequencer around the stack ram
// A request is taken at a rising edge with start high and busy low; its
// results come one per cycle, each for a single cycle marked by
// rsp_strobe, and the receiver cannot hold them off. Push, pop, peek,
// listings and unknown operations answer from the next cycle on. Push,
// pop, peek and unknown operations leave the engine idle, so a new request
// may follow in the next cycle. A swap steps through S_IDLE, S_SW1, S_SW2
// and S_SW3, set by the single ram read and write port: two reads then two
// write-backs, and its one result is issued with the second write-back.
// A listing reads the ram once per entry, top first. An error (empty,
// too short, full) halts the engine until reset; every request after
// that answers with status halted.
`default_nettype none
`include "assert_macros.svh"

module bytecode_stack_engine #(
   parameter int DEPTH = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [2:0]                          req_op,
   input  wire logic signed [bse_pkg::DATA_W-1:0]   req_push_value,
   output logic                                     rsp_strobe,
   output logic signed [bse_pkg::DATA_W-1:0]        rsp_data_value,
   output logic                                     rsp_has_value,
   output logic [2:0]                               rsp_status,
   output logic                                     rsp_last
);

   localparam int AW = $clog2(DEPTH);
   localparam int OW = $clog2(DEPTH + 1);

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LIST = 3'd1;
   localparam logic [2:0] S_SW1  = 3'd2;
   localparam logic [2:0] S_SW2  = 3'd3;
   localparam logic [2:0] S_SW3  = 3'd4;

   logic [2:0]                  state_ff, state_in;
   logic [OW-1:0]               occ_ff, occ_in;
   logic                        halted_ff, halted_in;
   logic [AW-1:0]               idx_ff, idx_in;
   logic [bse_pkg::DATA_W-1:0]  top_ff, top_in;

   logic [OW-1:0]               occ_m1, occ_m2;
   logic                        accept, full, empty;

   logic                        ram_wr_en, ram_rd_en;
   logic [AW-1:0]               ram_wr_addr, ram_rd_addr;
   logic [bse_pkg::DATA_W-1:0]  ram_wr_data, ram_rd_data;

   bse_pkg::rsp_ctl_type        rsp_ctl;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start & ~busy;
   assign occ_m1 = occ_ff - OW'(1);
   assign occ_m2 = occ_ff - OW'(2);
   assign full   = (occ_ff == OW'(DEPTH));
   assign empty  = (occ_ff == '0);

   always_comb begin
      state_in    = state_ff;
      occ_in      = occ_ff;
      halted_in   = halted_ff;
      idx_in      = idx_ff;
      top_in      = top_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = occ_m1[AW-1:0];
      ram_wr_en   = 1'b0;
      ram_wr_addr = occ_ff[AW-1:0];
      ram_wr_data = req_push_value;
      rsp_ctl     = '0;
      rsp_ctl.status = bse_pkg::STATUS_OK;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_ctl.strobe = 1'b1;
               rsp_ctl.last   = 1'b1;
               if (halted_ff) begin
                  rsp_ctl.status = bse_pkg::STATUS_HALTED;
               end else begin
                  unique case (req_op)
                     bse_pkg::OP_PUSH: begin
                        if (full) begin
                           halted_in      = 1'b1;
                           rsp_ctl.status = bse_pkg::STATUS_FULL;
                        end else begin
                           ram_wr_en = 1'b1;
                           occ_in    = occ_ff + OW'(1);
                        end
                     end
                     bse_pkg::OP_LIST: begin
                        // empty stack lists as a single bare ok result
                        if (!empty) begin
                           ram_rd_en         = 1'b1;
                           rsp_ctl.from_ram  = 1'b1;
                           rsp_ctl.has_value = 1'b1;
                           rsp_ctl.last      = (occ_ff == OW'(1));
                           idx_in            = occ_m2[AW-1:0];
                           if (occ_ff != OW'(1)) begin
                              state_in = S_LIST;
                           end
                        end
                     end
                     bse_pkg::OP_PEEK: begin
                        if (empty) begin
                           halted_in      = 1'b1;
                           rsp_ctl.status = bse_pkg::STATUS_EMPTY;
                        end else begin
                           ram_rd_en         = 1'b1;
                           rsp_ctl.from_ram  = 1'b1;
                           rsp_ctl.has_value = 1'b1;
                        end
                     end
                     bse_pkg::OP_POP: begin
                        if (empty) begin
                           halted_in      = 1'b1;
                           rsp_ctl.status = bse_pkg::STATUS_EMPTY;
                        end else begin
                           occ_in = occ_m1;
                        end
                     end
                     bse_pkg::OP_SWAP: begin
                        if (occ_ff < OW'(2)) begin
                           halted_in      = 1'b1;
                           rsp_ctl.status = bse_pkg::STATUS_SHORT;
                        end else begin
                           // fetch the top first, result comes at write-back
                           ram_rd_en      = 1'b1;
                           rsp_ctl.strobe = 1'b0;
                           state_in       = S_SW1;
                        end
                     end
                     default: begin
                        // unknown operation: plain ok, no effect
                     end
                  endcase
               end
            end
         end
         S_LIST: begin
            // one entry per cycle, walking down to the bottom
            ram_rd_en         = 1'b1;
            ram_rd_addr       = idx_ff;
            rsp_ctl.strobe    = 1'b1;
            rsp_ctl.from_ram  = 1'b1;
            rsp_ctl.has_value = 1'b1;
            rsp_ctl.last      = (idx_ff == '0);
            if (idx_ff == '0) begin
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff - AW'(1);
            end
         end
         S_SW1: begin
            // top is on the read port now; fetch the second entry
            top_in      = ram_rd_data;
            ram_rd_en   = 1'b1;
            ram_rd_addr = occ_m2[AW-1:0];
            state_in    = S_SW2;
         end
         S_SW2: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = occ_m1[AW-1:0];
            ram_wr_data = ram_rd_data;
            state_in    = S_SW3;
         end
         S_SW3: begin
            ram_wr_en      = 1'b1;
            ram_wr_addr    = occ_m2[AW-1:0];
            ram_wr_data    = top_ff;
            rsp_ctl.strobe = 1'b1;
            rsp_ctl.last   = 1'b1;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         occ_ff    <= '0;
         halted_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         occ_ff    <= occ_in;
         halted_ff <= halted_in;
      end
   end

   // list index and swap holding register carry payload only
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      top_ff <= top_in;
   end

   bse_ram #(
      .WIDTH (bse_pkg::DATA_W),
      .DEPTH (DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bse_rsp u_rsp (
      .clock          (clock),
      .reset          (reset),
      .ctl_in         (rsp_ctl),
      .ram_data       (ram_rd_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_data_value (rsp_data_value),
      .rsp_has_value  (rsp_has_value),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

   // the halt is only ever cleared by reset
   `ASSERT_NEXT(a_halt_sticky, clock, reset, halted_ff, halted_ff, "halt released without reset")
   // occupancy never passes the stack depth
   `ASSERT_ALWAYS(a_occ_bound, clock, reset, occ_ff <= OW'(DEPTH), "occupancy beyond depth")
   // a push write never lands on a full stack
   `ASSERT_ALWAYS(a_wr_room, clock, reset,
      !ram_wr_en || state_ff == S_SW2 || state_ff == S_SW3 || !full, "write to full stack")

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// self-checking bench for the bytecode stack engine: directed table, random traffic, final fault
module tb_top;

   localparam int DATA_W         = bse_pkg::DATA_W;
   localparam int DEPTH          = 64;
   localparam int RANDOM_REQS    = 80;
   localparam int WATCHDOG_LIMIT = 1000;  // cycles with no request and no result taken
   localparam int DRAIN_CYCLES   = 16;    // settle time once every result is in

   // opcodes the engine does not decode, answered with a plain ok
   localparam logic [2:0] OP_RSV_FIRST = 3'd5;
   localparam logic [2:0] OP_RSV_MID   = 3'd6;
   localparam logic [2:0] OP_RSV_LAST  = 3'd7;

   // one result as it leaves the engine
   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic              has;
      logic [2:0]        status;
      logic              last;
   } stack_rsp_type;

   // one row of the directed table; typed rows carry their answer
   typedef struct {
      logic [2:0]        op;
      logic [DATA_W-1:0] val;
      bit                typed;
      stack_rsp_type     rsp;
   } stim_row_type;

   // the error that closes the run, since only reset clears a halt
   typedef enum int {
      FAULT_FULL,
      FAULT_PEEK_EMPTY,
      FAULT_POP_EMPTY,
      FAULT_SWAP_SHORT
   } fault_kind_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [2:0]               req_op = bse_pkg::OP_PUSH;
   logic signed [DATA_W-1:0] req_push_value = '0;
   logic                     rsp_strobe;
   logic signed [DATA_W-1:0] rsp_data_value;
   logic                     rsp_has_value;
   logic [2:0]               rsp_status;
   logic                     rsp_last;

   // shadow copy of the operand stack
   logic [DATA_W-1:0] shadow_stack [DEPTH];
   int                shadow_depth;
   bit                shadow_halted;

   stack_rsp_type step_rsp[$];     // answers of the request just taken
   stack_rsp_type pending_rsp[$];  // answers still owed by the engine
   stim_row_type  stim_rows[$];
   stack_rsp_type want;

   int             fails;
   int             req_count;
   int             rsp_count;
   int             list_count;
   int             deepest;
   int             halted_reqs;
   int             burst_left;
   int             idle_cycles;
   fault_kind_type fault;

   bytecode_stack_engine #(
      .DEPTH(DEPTH)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_push_value (req_push_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_data_value (rsp_data_value),
      .rsp_has_value  (rsp_has_value),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic stack_rsp_type make_rsp(logic [DATA_W-1:0] data, logic has,
                                              logic [2:0] status, logic last);
      stack_rsp_type r;
      r.data   = data;
      r.has    = has;
      r.status = status;
      r.last   = last;
      return r;
   endfunction

   // works out the answers to one request and moves the shadow stack on
   function automatic void predict_stack_op(logic [2:0] op, logic [DATA_W-1:0] val);
      logic [DATA_W-1:0] tmp;
      int k;
      step_rsp.delete();
      if (shadow_halted) begin
         step_rsp.push_back(make_rsp('0, 1'b0, bse_pkg::STATUS_HALTED, 1'b1));
         return;
      end
      case (op)
         bse_pkg::OP_PUSH: begin
            if (shadow_depth >= DEPTH) begin
               shadow_halted = 1'b1;
               step_rsp.push_back(make_rsp('0, 1'b0, bse_pkg::STATUS_FULL, 1'b1));
            end else begin
               shadow_stack[shadow_depth] = val;
               shadow_depth++;
               if (shadow_depth > deepest) deepest = shadow_depth;
               step_rsp.push_back(make_rsp('0, 1'b0, bse_pkg::STATUS_OK, 1'b1));
            end
         end
         bse_pkg::OP_LIST: begin
            list_count++;
            // an empty listing still answers once, marked last
            if (shadow_depth == 0)
               step_rsp.push_back(make_rsp('0, 1'b0, bse_pkg::STATUS_OK, 1'b1));
            for (k = shadow_depth - 1; k >= 0; k--)
               step_rsp.push_back(make_rsp(shadow_stack[k], 1'b1, bse_pkg::STATUS_OK, k == 0));
         end
         bse_pkg::OP_PEEK: begin
            if (shadow_depth == 0) begin
               shadow_halted = 1'b1;
               step_rsp.push_back(make_rsp('0, 1'b0, bse_pkg::STATUS_EMPTY, 1'b1));
            end else begin
               step_rsp.push_back(make_rsp(shadow_stack[shadow_depth-1], 1'b1,
                                           bse_pkg::STATUS_OK, 1'b1));
            end
         end
         bse_pkg::OP_POP: begin
            if (shadow_depth == 0) begin
               shadow_halted = 1'b1;
               step_rsp.push_back(make_rsp('0, 1'b0, bse_pkg::STATUS_EMPTY, 1'b1));
            end else begin
               shadow_depth--;
               step_rsp.push_back(make_rsp('0, 1'b0, bse_pkg::STATUS_OK, 1'b1));
            end
         end
         bse_pkg::OP_SWAP: begin
            if (shadow_depth < 2) begin
               shadow_halted = 1'b1;
               step_rsp.push_back(make_rsp('0, 1'b0, bse_pkg::STATUS_SHORT, 1'b1));
            end else begin
               tmp                          = shadow_stack[shadow_depth-1];
               shadow_stack[shadow_depth-1] = shadow_stack[shadow_depth-2];
               shadow_stack[shadow_depth-2] = tmp;
               step_rsp.push_back(make_rsp('0, 1'b0, bse_pkg::STATUS_OK, 1'b1));
            end
         end
         default: begin
            step_rsp.push_back(make_rsp('0, 1'b0, bse_pkg::STATUS_OK, 1'b1));
         end
      endcase
   endfunction

   // random operand, leaning on the extremes now and then
   function automatic logic [DATA_W-1:0] rand_word();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'h0000_0000;
         3:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // legal operation for the current depth, with some undecoded noise
   function automatic logic [2:0] pick_op();
      int r;
      r = $urandom_range(0, 99);
      if (r < 6)  return 3'($urandom_range(OP_RSV_FIRST, OP_RSV_LAST));
      if (r < 14) return bse_pkg::OP_LIST;
      if (r < 44) return (shadow_depth < DEPTH) ? bse_pkg::OP_PUSH : bse_pkg::OP_POP;
      if (r < 68) return (shadow_depth > 0) ? bse_pkg::OP_POP : bse_pkg::OP_PUSH;
      if (r < 82) return (shadow_depth > 0) ? bse_pkg::OP_PEEK : bse_pkg::OP_PUSH;
      return (shadow_depth >= 2) ? bse_pkg::OP_SWAP : bse_pkg::OP_PUSH;
   endfunction

   // start is left high so a following request can be taken back to back
   task automatic send_request(input logic [2:0] op, input logic [DATA_W-1:0] val,
                               input bit typed, input stack_rsp_type typed_rsp);
      start          <= 1'b1;
      req_op         <= op;
      req_push_value <= val;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_stack_op(op, val);
      if (typed) begin
         pending_rsp.push_back(typed_rsp);
      end else begin
         foreach (step_rsp[k]) pending_rsp.push_back(step_rsp[k]);
      end
      req_count++;
   endtask

   task automatic idle_for(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // bursts of random length, mostly with a random gap behind them
   task automatic pace();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 8));
      end
   endtask

   // sender holds off until every owed result has come back
   task automatic wait_for_drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic add_row(input logic [2:0] op, input logic [DATA_W-1:0] val,
                          input bit typed, input logic [DATA_W-1:0] data,
                          input logic has, input logic [2:0] status);
      stim_row_type row;
      row.op    = op;
      row.val   = val;
      row.typed = typed;
      row.rsp   = make_rsp(data, has, status, 1'b1);
      stim_rows.push_back(row);
   endtask

   // result checker: the engine cannot be stalled, so every strobe is taken
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         rsp_count++;
         if (pending_rsp.size() == 0) begin
            $error("result with nothing owed: data %h has %0b status %0d last %0b",
                   rsp_data_value, rsp_has_value, rsp_status, rsp_last);
            fails++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data_value !== want.data) begin
               $error("data_value: expected %h, got %h", want.data, rsp_data_value);
               fails++;
            end
            if (rsp_has_value !== want.has) begin
               $error("has_value: expected %0b, got %0b", want.has, rsp_has_value);
               fails++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               fails++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_last);
               fails++;
            end
         end
      end
   end

   // watchdog on cycles where neither side moves anything
   initial begin
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_strobe) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("watchdog: %0d idle cycles, %0d results still owed", idle_cycles,
               pending_rsp.size());
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int i;
      int target;
      logic [2:0] op;

      fails         = 0;
      req_count     = 0;
      rsp_count     = 0;
      list_count    = 0;
      deepest       = 0;
      halted_reqs   = 0;
      burst_left    = 0;
      shadow_depth  = 0;
      shadow_halted = 1'b0;

      // directed table: obvious answers typed in, the rest from the shadow stack
      add_row(bse_pkg::OP_LIST, 32'h1234_5678, 1'b1, '0, 1'b0,
              bse_pkg::STATUS_OK);  // list of empty stack
      add_row(bse_pkg::OP_PUSH, 32'h8000_0000, 1'b1, '0, 1'b0, bse_pkg::STATUS_OK);
      add_row(bse_pkg::OP_PUSH, 32'h7fff_ffff, 1'b1, '0, 1'b0, bse_pkg::STATUS_OK);
      add_row(bse_pkg::OP_PEEK, 32'h0000_0000, 1'b1, 32'h7fff_ffff, 1'b1, bse_pkg::STATUS_OK);
      add_row(bse_pkg::OP_PUSH, 32'h0000_0000, 1'b1, '0, 1'b0,
              bse_pkg::STATUS_OK);  // zero is a valid push
      add_row(bse_pkg::OP_PEEK, 32'hffff_ffff, 1'b1, 32'h0000_0000, 1'b1, bse_pkg::STATUS_OK);
      add_row(bse_pkg::OP_PUSH, 32'hffff_ffff, 1'b1, '0, 1'b0, bse_pkg::STATUS_OK);
      add_row(bse_pkg::OP_PUSH, 32'ha5a5_a5a5, 1'b0, '0, 1'b0, bse_pkg::STATUS_OK);
      add_row(bse_pkg::OP_PUSH, 32'h5a5a_5a5a, 1'b0, '0, 1'b0, bse_pkg::STATUS_OK);
      add_row(bse_pkg::OP_LIST, 32'h0000_0000, 1'b0, '0, 1'b0, bse_pkg::STATUS_OK);
      add_row(bse_pkg::OP_SWAP, 32'hffff_ffff, 1'b1, '0, 1'b0, bse_pkg::STATUS_OK);
      add_row(bse_pkg::OP_PEEK, 32'h0000_0000, 1'b1, 32'ha5a5_a5a5, 1'b1, bse_pkg::STATUS_OK);
      add_row(bse_pkg::OP_LIST, 32'hffff_ffff, 1'b0, '0, 1'b0, bse_pkg::STATUS_OK);
      add_row(bse_pkg::OP_POP,  32'h8000_0000, 1'b1, '0, 1'b0, bse_pkg::STATUS_OK);
      add_row(bse_pkg::OP_PEEK, 32'h7fff_ffff, 1'b0, '0, 1'b0, bse_pkg::STATUS_OK);
      add_row(OP_RSV_FIRST,     32'hffff_ffff, 1'b1, '0, 1'b0,
              bse_pkg::STATUS_OK);  // undecoded opcodes
      add_row(OP_RSV_MID,       32'h0000_0000, 1'b1, '0, 1'b0, bse_pkg::STATUS_OK);
      add_row(OP_RSV_LAST,      32'h8000_0000, 1'b1, '0, 1'b0, bse_pkg::STATUS_OK);
      add_row(bse_pkg::OP_SWAP, 32'h0000_0000, 1'b0, '0, 1'b0, bse_pkg::STATUS_OK);
      add_row(bse_pkg::OP_LIST, 32'h0000_0000, 1'b0, '0, 1'b0, bse_pkg::STATUS_OK);
      add_row(bse_pkg::OP_POP,  32'h0000_0000, 1'b0, '0, 1'b0, bse_pkg::STATUS_OK);
      add_row(bse_pkg::OP_POP,  32'h0000_0000, 1'b0, '0, 1'b0, bse_pkg::STATUS_OK);
      add_row(bse_pkg::OP_POP,  32'h0000_0000, 1'b0, '0, 1'b0, bse_pkg::STATUS_OK);
      add_row(bse_pkg::OP_POP,  32'h0000_0000, 1'b0, '0, 1'b0, bse_pkg::STATUS_OK);
      add_row(bse_pkg::OP_LIST, 32'h0000_0000, 1'b0, '0, 1'b0,
              bse_pkg::STATUS_OK);  // single entry left

      // the only reset of the run
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_rows[k]) begin
         send_request(stim_rows[k].op, stim_rows[k].val, stim_rows[k].typed, stim_rows[k].rsp);
         pace();
      end

      // random traffic, legal for the current depth, with one fill to the brim halfway
      for (i = 0; i < RANDOM_REQS; i++) begin
         if (i == RANDOM_REQS / 2) begin
            wait_for_drain();
            while (shadow_depth < DEPTH) begin
               send_request(bse_pkg::OP_PUSH, rand_word(), 1'b0, '0);
               pace();
            end
            send_request(bse_pkg::OP_LIST, rand_word(), 1'b0, '0);  // longest listing
            pace();
            send_request(bse_pkg::OP_SWAP, rand_word(), 1'b0, '0);
            pace();
            send_request(bse_pkg::OP_PEEK, rand_word(), 1'b0, '0);
            pace();
            target = $urandom_range(0, 6);
            while (shadow_depth > target) begin
               send_request(bse_pkg::OP_POP, rand_word(), 1'b0, '0);
               pace();
            end
         end
         op = pick_op();
         send_request(op, rand_word(), 1'b0, '0);
         pace();
      end

      // close on one error of a random kind; every request after it sees the halt
      wait_for_drain();
      fault = fault_kind_type'($urandom_range(0, 3));
      case (fault)
         FAULT_FULL: begin
            while (shadow_depth < DEPTH) begin
               send_request(bse_pkg::OP_PUSH, rand_word(), 1'b0, '0);
               pace();
            end
            send_request(bse_pkg::OP_PUSH, rand_word(), 1'b1,
                         make_rsp('0, 1'b0, bse_pkg::STATUS_FULL, 1'b1));
         end
         FAULT_PEEK_EMPTY, FAULT_POP_EMPTY: begin
            while (shadow_depth > 0) begin
               send_request(bse_pkg::OP_POP, rand_word(), 1'b0, '0);
               pace();
            end
            send_request((fault == FAULT_PEEK_EMPTY) ? bse_pkg::OP_PEEK : bse_pkg::OP_POP,
                         rand_word(), 1'b1, make_rsp('0, 1'b0, bse_pkg::STATUS_EMPTY, 1'b1));
         end
         default: begin
            while (shadow_depth > 1) begin
               send_request(bse_pkg::OP_POP, rand_word(), 1'b0, '0);
               pace();
            end
            // too short with one entry or with none
            if (shadow_depth == 0 && $urandom_range(0, 1) == 1) begin
               send_request(bse_pkg::OP_PUSH, rand_word(), 1'b0, '0);
               pace();
            end
            send_request(bse_pkg::OP_SWAP, rand_word(), 1'b1,
                         make_rsp('0, 1'b0, bse_pkg::STATUS_SHORT, 1'b1));
         end
      endcase
      pace();
      for (i = 0; i < 8 + $urandom_range(0, 8); i++) begin
         send_request(3'(i), rand_word(), 1'b1,
                      make_rsp('0, 1'b0, bse_pkg::STATUS_HALTED, 1'b1));
         halted_reqs++;
         pace();
      end

      // let the last results come in, then watch for strays
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d requests, %0d results, %0d listings, deepest stack %0d",
               req_count, rsp_count, list_count, deepest);
      $display("summary: closing fault %s, then %0d requests while halted",
               fault.name(), halted_reqs);
      if (fails == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/bse_pkg.sv
rtl/core/bse_ram.sv
rtl/core/bse_rsp.sv
rtl/core/bytecode_stack_engine.sv
bench/tb_top.sv
